>>> hdl/blgs_pkg.sv
package blgs_pkg;

  localparam int MaxEdge     = 4096;
  localparam int MaxColumns  = 1024;
  localparam int CellLimit   = 65536;
  localparam int RowReach    = 1024;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegCols   = 2'd2;
  localparam logic [1:0] RegRows   = 2'd3;

  typedef struct packed {
    logic load;
    logic finish;
  } blgs_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic emit;
    logic bad;
  } blgs_sts_t;

endpackage

>>> hdl/bgra_luma_grid_signature_core.sv
// channel | signals           | contents
// s_axis  | s_axis_t*         | pixel: tdata blue,green,red; tuser start_of_frame
// m_axis  | m_axis_t*         | cell: tdata row,col,luma; tlast last_cell; tuser config_error
// apb     | p*                | image_width, image_height, column_limit, row_limit
// inside the frame the shared 26-step divider computes up to 23 quotients, for band
// bounds, sample slots and the cell mean, plus the accumulator update
// reset is synchronous and restores the default 640x480 grid of 64x64
// a pending result holds the input side until it is taken
module bgra_luma_grid_signature_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // blue, green, red
  input  logic        s_axis_tuser,   // start_of_frame
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // cell_row, cell_column, cell_luma, pad
  output logic        m_axis_tlast,   // last_cell
  output logic        m_axis_tuser,   // config_error
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import blgs_pkg::*;

  logic [12:0] image_width, image_height;
  logic [10:0] column_limit, row_limit;
  blgs_cmd_t cmd;
  blgs_sts_t sts;
  logic [9:0] cell_row, cell_column;
  logic [7:0] cell_luma;

  assign pready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 13'd640; image_height <= 13'd480;
      column_limit <= 11'd64; row_limit <= 11'd64;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        RegWidth:  image_width  <= pwdata[12:0];
        RegHeight: image_height <= pwdata[12:0];
        RegCols:   column_limit <= pwdata[10:0];
        RegRows:   row_limit    <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegWidth:  prdata = 32'(image_width);
      RegHeight: prdata = 32'(image_height);
      RegCols:   prdata = 32'(column_limit);
      RegRows:   prdata = 32'(row_limit);
      default:   prdata = '0;
    endcase
  end

  blgs_control u_ctl (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_ready(m_axis_tready), .out_valid(m_axis_tvalid), .cmd, .sts
  );

  blgs_datapath u_dp (
    .clk, .rst, .cmd, .sts,
    .blue(s_axis_tdata[7:0]), .green(s_axis_tdata[15:8]), .red(s_axis_tdata[23:16]),
    .start_of_frame(s_axis_tuser),
    .image_width, .image_height, .column_limit, .row_limit,
    .cell_row, .cell_column, .cell_luma,
    .last_cell(m_axis_tlast), .config_error(m_axis_tuser)
  );

  assign m_axis_tdata = {4'b0, cell_luma, cell_column, cell_row};
endmodule

>>> hdl/blgs_datapath.sv
module blgs_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  blgs_pkg::blgs_cmd_t          cmd,
  output blgs_pkg::blgs_sts_t          sts,
  input  logic [7:0]                   blue,
  input  logic [7:0]                   green,
  input  logic [7:0]                   red,
  input  logic                         start_of_frame,
  input  logic [12:0]                  image_width,
  input  logic [12:0]                  image_height,
  input  logic [10:0]                  column_limit,
  input  logic [10:0]                  row_limit,
  output logic [9:0]                   cell_row,
  output logic [9:0]                   cell_column,
  output logic [7:0]                   cell_luma,
  output logic                         last_cell,
  output logic                         config_error
);
  import blgs_pkg::*;

  // generic restoring divider shared by all quotients
  logic [25:0] dnum;
  logic [13:0] dden;
  logic [25:0] dquo;
  logic [14:0] drem;
  logic [4:0]  dcnt;
  logic        dbusy;
  logic        dstart;
  logic [25:0] dnum_in;
  logic [13:0] dden_in;
  logic [14:0] dtrial;

  assign dtrial = {drem[13:0], dnum[25]};

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      dcnt  <= '0;
    end else if (dstart) begin
      dbusy <= 1'b1;
      dcnt  <= 5'd26;
      dnum  <= dnum_in;
      dden  <= dden_in;
      drem  <= '0;
      dquo  <= '0;
    end else if (dbusy) begin
      dnum <= {dnum[24:0], 1'b0};
      if (dtrial >= {1'b0, dden}) begin
        drem <= dtrial - {1'b0, dden};
        dquo <= {dquo[24:0], 1'b1};
      end else begin
        drem <= dtrial;
        dquo <= {dquo[24:0], 1'b0};
      end
      dcnt <= dcnt - 5'd1;
      if (dcnt == 5'd1) dbusy <= 1'b0;
    end
  end

  // pixel state
  logic [11:0] px, py;
  logic [7:0]  b_q, g_q, r_q;
  logic [12:0] cols, rows;
  logic        bad;
  logic [26:0] prod;

  always_comb begin
    cols = (image_width < {2'b0, column_limit}) ? image_width : {2'b0, column_limit};
    rows = (image_height < {2'b0, row_limit}) ? image_height : {2'b0, row_limit};
    prod = 27'(column_limit) * 27'(row_limit);
    bad  = (image_width == '0) || (image_height == '0) || (column_limit == '0) ||
           (row_limit == '0) || (image_width > 13'(MaxEdge)) ||
           (image_height > 13'(MaxEdge)) || (prod > 27'(CellLimit)) ||
           (cols > 13'(MaxColumns)) || (rows > 13'(RowReach));
  end

  // division sequence: phase 0 row index, 1 top, 2 bottom, row sample slot search,
  // then 3 col, 4 left, 5 right, column sample slot search, accumulator update, mean
  typedef enum logic [3:0] {
    P_R, P_TOP, P_BOT, P_C, P_LEFT, P_RIGHT, P_SY, P_SX, P_ACC, P_MEAN, P_DONE
  } phase_t;
  phase_t      ph;
  logic        wait_div;
  logic [3:0]  slot;
  logic [9:0]  rr, cc;
  logic [12:0] top, bot, left, right;
  logic [3:0]  sy, sx, ny, nx;
  logic [13:0] sums [MaxColumns];
  logic [13:0] sum_rd;
  logic [13:0] sum_new;
  logic [7:0]  luma;
  logic [17:0] lsum;
  logic [12:0] span;
  logic [12:0] offs;
  logic [3:0]  nn;
  logic        emit_q;
  logic [6:0]  cnt;

  assign lsum = 18'(29 * b_q) + 18'(150 * g_q) + 18'(77 * r_q) + 18'd128;
  assign luma = lsum[15:8];
  assign span = (ph == P_SY) ? (bot - top) : (right - left);
  assign offs = (ph == P_SY) ? (13'(py) - top) : (13'(px) - left);
  assign nn   = (span < 13'd8) ? span[3:0] : 4'd8;
  assign cnt  = 7'(nx * ny);

  always_comb begin
    dstart  = 1'b0;
    dnum_in = '0;
    dden_in = 14'd1;
    if (!wait_div && !dbusy) begin
      unique case (ph)
        P_R:     begin dstart = 1'b1; dnum_in = 26'((13'(py) + 13'd1) * rows - 26'd1);
                   dden_in = 14'(image_height); end
        P_TOP:   begin dstart = 1'b1; dnum_in = 26'(rr * image_height); dden_in = 14'(rows); end
        P_BOT:   begin dstart = 1'b1; dnum_in = 26'((11'(rr) + 11'd1) * image_height);
                   dden_in = 14'(rows); end
        P_C:     begin dstart = 1'b1; dnum_in = 26'((13'(px) + 13'd1) * cols - 26'd1);
                   dden_in = 14'(image_width); end
        P_LEFT:  begin dstart = 1'b1; dnum_in = 26'(cc * image_width); dden_in = 14'(cols); end
        P_RIGHT: begin dstart = 1'b1; dnum_in = 26'((11'(cc) + 11'd1) * image_width);
                   dden_in = 14'(cols); end
        P_SY, P_SX: begin dstart = 1'b1; dnum_in = 26'((5'(slot) * 5'd2 + 5'd1) * span);
                   dden_in = 14'({nn, 1'b0}); end
        P_MEAN:  begin dstart = 1'b1; dnum_in = 26'(sum_new + 14'(cnt >> 1));
                   dden_in = 14'(cnt); end
        default: ;
      endcase
    end
  end

  assign sum_new = (sx == 4'd0 && sy == 4'd0) ? 14'(luma) : sum_rd + 14'(luma);

  always_ff @(posedge clk) begin
    if (rst) begin
      px <= '0; py <= '0; ph <= P_DONE; wait_div <= 1'b0;
    end else begin
      if (cmd.load) begin
        b_q <= blue; g_q <= green; r_q <= red;
        wait_div <= 1'b0; slot <= '0;
        if (start_of_frame || bad) begin px <= '0; py <= '0; end
        if (bad) begin
          ph <= P_DONE;
          config_error <= 1'b1; cell_row <= '0; cell_column <= '0;
          cell_luma <= '0; last_cell <= 1'b0;
        end else if ((start_of_frame ? 13'd0 : 13'(px)) < image_width &&
                     (start_of_frame ? 13'd0 : 13'(py)) < image_height) begin
          ph <= P_R;
        end else ph <= P_DONE;
      end else if (cmd.finish) begin
        if (13'(px) + 13'd1 >= image_width) begin
          px <= '0;
          py <= (13'(py) + 13'd1 >= image_height) ? 12'd0 : py + 12'd1;
        end else px <= px + 12'd1;
      end else if (dstart) wait_div <= 1'b1;
      else if (ph == P_ACC) begin
        ph <= (sx == nx - 4'd1 && sy == ny - 4'd1) ? P_MEAN : P_DONE;
      end else if (wait_div && !dbusy) begin
        wait_div <= 1'b0;
        unique case (ph)
          P_R:     begin rr <= dquo[9:0]; ph <= P_TOP; end
          P_TOP:   begin top <= dquo[12:0]; ph <= P_BOT; end
          P_BOT:   begin bot <= dquo[12:0]; ph <= P_SY; slot <= '0; end
          P_SY: begin
            ny <= nn;
            if (dquo[12:0] == offs) begin sy <= slot; ph <= P_C; end
            else if (slot + 4'd1 >= nn) ph <= P_DONE;
            else slot <= slot + 4'd1;
          end
          P_C:     begin cc <= dquo[9:0]; ph <= P_LEFT; end
          P_LEFT:  begin left <= dquo[12:0]; ph <= P_RIGHT; end
          P_RIGHT: begin right <= dquo[12:0]; ph <= P_SX; slot <= '0; end
          P_SX: begin
            nx <= nn;
            if (dquo[12:0] == offs) begin
              sx <= slot; sum_rd <= sums[cc]; ph <= P_ACC;
            end else if (slot + 4'd1 >= nn) ph <= P_DONE;
            else slot <= slot + 4'd1;
          end
          P_MEAN: begin
            ph <= P_DONE; config_error <= 1'b0;
            cell_row <= rr; cell_column <= cc;
            cell_luma <= (dquo > 26'd255) ? 8'd255 : dquo[7:0];
            last_cell <= (13'(rr) == rows - 13'd1) && (13'(cc) == cols - 13'd1);
          end
          default: ph <= P_DONE;
        endcase
      end
    end
  end

  // result strobe: error on a bad setup, or the cell mean is ready
  always_ff @(posedge clk) begin
    if (rst) emit_q <= 1'b0;
    else emit_q <= (cmd.load && bad) || (wait_div && !dbusy && ph == P_MEAN);
  end

  // accumulator write in the cycle after the registered read
  always_ff @(posedge clk) begin
    if (ph == P_ACC) sums[cc] <= sum_new;
  end

  assign sts.div_busy   = (ph != P_DONE);
  assign sts.emit       = emit_q;
  assign sts.bad        = bad;
endmodule

>>> hdl/blgs_control.sv
module blgs_control (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  output blgs_pkg::blgs_cmd_t cmd,
  input  blgs_pkg::blgs_sts_t sts
);
  import blgs_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_WORK, S_STEP, S_HOLD} state_t;
  state_t state;

  assign in_ready = (state == S_IDLE) && !out_valid;
  always_comb begin
    cmd = '0;
    cmd.load   = in_valid && in_ready;
    cmd.finish = (state == S_STEP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0;
    end else begin
      if (sts.emit) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (cmd.load) state <= sts.bad ? S_HOLD : S_WORK;
        S_WORK: if (!sts.div_busy) state <= S_STEP;
        S_STEP: state <= S_HOLD;
        S_HOLD: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> hdl/blgs_checker.sv
module blgs_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic m_axis_tlast,
  input logic m_axis_tuser,
  input logic [31:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
  a_noin: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken while result waits");
  a_err: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'd0 && !m_axis_tlast)
    else $error("error result carries data");
endmodule

bind bgra_luma_grid_signature_core blgs_checker u_chk (.*);

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import blgs_pkg::*;

  // pixel request and cell result as the testbench sees them
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       sof;
  } pixel_t;

  typedef struct packed {
    logic [9:0] row;
    logic [9:0] col;
    logic [7:0] luma;
    logic       last;
    logic       err;
  } cell_t;

  // directed row: pixel plus optional typed-in expected cell
  typedef struct {
    pixel_t pix;
    bit     has_exp;
    cell_t  exp;
  } row_t;

  localparam int LIMIT = 4_000_000;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  always #4 clk = ~clk;

  bgra_luma_grid_signature_core DUT (.*);

  // predictor copy of registers and state
  int unsigned img_w, img_h, col_lim, row_lim;
  logic [13:0] col_acc [MaxColumns];
  int unsigned pos_x, pos_y;

  cell_t cells_due[$];
  int    fails = 0;
  int    cycles = 0;
  int    send_idle = 0;  // percent
  int    recv_stall = 0; // percent

  function automatic int slot_of(int unsigned off, int unsigned len, output int unsigned n);
    longint unsigned p;
    n = (len < 8) ? len : 8;
    for (int unsigned s = 0; s < n; s++) begin
      p = (longint'(s) * 2 + 1) * len / (2 * n);
      if (p == off) return s;
    end
    return -1;
  endfunction

  function automatic bit grid_bad();
    int unsigned c, r;
    if (img_w == 0 || img_h == 0 || col_lim == 0 || row_lim == 0) return 1;
    if (img_w > MaxEdge || img_h > MaxEdge) return 1;
    if (longint'(col_lim) * row_lim > CellLimit) return 1;
    c = img_w < col_lim ? img_w : col_lim;
    r = img_h < row_lim ? img_h : row_lim;
    return c > MaxColumns || r > RowReach;
  endfunction

  // predicts the cell (if any) finished by one pixel
  function automatic bit predict_cell(pixel_t p, output cell_t res);
    int unsigned cols, rows, r, top, bot, c, lft, rgt, ny, nx, luma, cnt, mean;
    int sy, sx;
    bit got = 0;
    res = '0;
    if (p.sof) begin
      pos_x = 0; pos_y = 0;
    end
    if (grid_bad()) begin
      res.err = 1;
      pos_x = 0; pos_y = 0;
      return 1;
    end
    if (pos_x < img_w && pos_y < img_h) begin
      cols = img_w < col_lim ? img_w : col_lim;
      rows = img_h < row_lim ? img_h : row_lim;
      r   = ((pos_y + 1) * rows - 1) / img_h;
      top = r * img_h / rows;
      bot = (r + 1) * img_h / rows;
      sy  = slot_of(pos_y - top, bot - top, ny);
      if (sy >= 0) begin
        c   = ((pos_x + 1) * cols - 1) / img_w;
        lft = c * img_w / cols;
        rgt = (c + 1) * img_w / cols;
        sx  = slot_of(pos_x - lft, rgt - lft, nx);
        if (sx >= 0 && c < MaxColumns) begin
          luma = (29 * p.blue + 150 * p.green + 77 * p.red + 128) >> 8;
          if (sx == 0 && sy == 0) col_acc[c] = 14'(luma);
          else col_acc[c] = 14'(col_acc[c] + luma);
          if (sx == nx - 1 && sy == ny - 1) begin
            cnt  = nx * ny;
            mean = (col_acc[c] + cnt / 2) / cnt;
            if (mean > 255) mean = 255;
            res.row  = 10'(r);
            res.col  = 10'(c);
            res.luma = 8'(mean);
            res.last = (r == rows - 1 && c == cols - 1);
            got = 1;
          end
        end
      end
    end
    pos_x++;
    if (pos_x >= img_w) begin
      pos_x = 0;
      pos_y++;
      if (pos_y >= img_h) pos_y = 0;
    end
    return got;
  endfunction

  // register write over the config port, setup then access
  task automatic write_reg(logic [1:0] idx, int unsigned val);
    @(negedge clk);
    psel = 1; penable = 0; pwrite = 1; paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk);
    penable = 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
    case (idx)
      RegWidth:  img_w   = val & 13'h1FFF;
      RegHeight: img_h   = val & 13'h1FFF;
      RegCols:   col_lim = val & 11'h7FF;
      default:   row_lim = val & 11'h7FF;
    endcase
  endtask

  // wait for outstanding cells and an idle core
  task automatic drain();
    while (cells_due.size() != 0 || !s_axis_tready) @(posedge clk);
  endtask

  task automatic set_grid(int unsigned w, int unsigned h, int unsigned c, int unsigned r);
    drain();
    write_reg(RegWidth, w);
    write_reg(RegHeight, h);
    write_reg(RegCols, c);
    write_reg(RegRows, r);
  endtask

  // one pixel request; predictor runs on acceptance
  task automatic send_pixel(pixel_t p, bit has_exp = 0, cell_t ex = '0);
    cell_t res;
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid = 0;
      @(negedge clk);
    end
    s_axis_tvalid = 1;
    s_axis_tdata  = {p.red, p.green, p.blue};
    s_axis_tuser  = p.sof;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (predict_cell(p, res)) begin
      cells_due = {cells_due, res};
      if (has_exp && res !== ex) begin
        $error("typed expectation differs from predictor: exp %h pred %h", ex, res);
        fails++;
      end
    end else if (has_exp) begin
      $error("typed expectation but no cell predicted");
      fails++;
    end
    @(negedge clk);
    s_axis_tvalid = 0;
  endtask

  function automatic pixel_t rnd_pixel(bit sof = 0);
    pixel_t p;
    p.blue = $urandom; p.green = $urandom; p.red = $urandom; p.sof = sof;
    return p;
  endfunction

  // stream n random pixels; the first, and about one in 200 of the rest, marked as start of frame
  task automatic send_frames(int n);
    for (int i = 0; i < n; i++) send_pixel(rnd_pixel(i == 0 || $urandom_range(199) == 0));
  endtask

  // receiver: random stalls, check against oldest expected cell
  always @(negedge clk) begin
    if (!rst) m_axis_tready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    cell_t got, ex;
    cycles++;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[9:0], m_axis_tdata[19:10], m_axis_tdata[27:20],
             m_axis_tlast, m_axis_tuser};
      if (cells_due.size() == 0) begin
        $error("cell with nothing expected: %h", got);
        fails++;
      end else begin
        ex = cells_due.pop_front();
        if (got.row !== ex.row) begin
          $error("cell_row exp %0d got %0d", ex.row, got.row); fails++;
        end
        if (got.col !== ex.col) begin
          $error("cell_column exp %0d got %0d", ex.col, got.col); fails++;
        end
        if (got.luma !== ex.luma) begin
          $error("cell_luma exp %0d got %0d", ex.luma, got.luma); fails++;
        end
        if (got.last !== ex.last) begin
          $error("last_cell exp %0d got %0d", ex.last, got.last); fails++;
        end
        if (got.err !== ex.err) begin
          $error("config_error exp %0d got %0d", ex.err, got.err); fails++;
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  row_t dir_rows [5];
  cell_t err_cell;
  cell_t one_cell;

  initial begin
    img_w = 640; img_h = 480; col_lim = 64; row_lim = 64;
    pos_x = 0; pos_y = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: 1x1 image is one cell of one sample, luma extremes and each primary alone
    err_cell = '0; err_cell.err = 1;
    one_cell = '0; one_cell.last = 1;
    set_grid(1, 1, 1, 1);
    dir_rows[0] = '{'{8'hFF, 8'hFF, 8'hFF, 1'b1}, 1, '{0, 0, 8'd255, 1, 0}};
    dir_rows[1] = '{'{8'h00, 8'h00, 8'h00, 1'b0}, 1, one_cell};
    dir_rows[2] = '{'{8'hFF, 8'h00, 8'h00, 1'b0}, 1, '{0, 0, 8'd29, 1, 0}};
    dir_rows[3] = '{'{8'h00, 8'hFF, 8'h00, 1'b0}, 1, '{0, 0, 8'd149, 1, 0}};
    dir_rows[4] = '{'{8'h00, 8'h00, 8'hFF, 1'b1}, 1, '{0, 0, 8'd77, 1, 0}};
    foreach (dir_rows[i]) send_pixel(dir_rows[i].pix, dir_rows[i].has_exp, dir_rows[i].exp);

    // invalid setups: each gives an error cell per pixel
    set_grid(0, 4, 4, 4);
    send_pixel(rnd_pixel(), 1, err_cell);
    set_grid(4097, 4, 4, 4);
    send_pixel(rnd_pixel(), 1, err_cell);
    set_grid(4, 4, 1024, 1024);   // cell product over the limit
    send_pixel(rnd_pixel(1), 1, err_cell);
    set_grid(4, 4, 0, 4);
    send_pixel(rnd_pixel(), 1, err_cell);
    set_grid(4, 4, 4, 0);
    send_pixel(rnd_pixel(), 1, err_cell);
    set_grid(2048, 4, 2047, 2);   // more grid columns than accumulators
    send_pixel(rnd_pixel(), 1, err_cell);
    set_grid(4, 2048, 2, 2047);   // more grid rows than allowed
    send_pixel(rnd_pixel(), 1, err_cell);
    set_grid(8191, 1, 1, 1);
    send_pixel(rnd_pixel(), 1, err_cell);

    // small frames with multi-sample cells, then accumulators carried over
    set_grid(5, 3, 2, 2);
    send_frames(15);
    set_grid(20, 18, 2, 2);       // spans over eight: sparse sample points
    send_frames(360);

    // idle phases
    send_idle = 77;
    set_grid(6, 4, 3, 2);
    send_frames(120);
    send_idle = 0; recv_stall = 77;
    set_grid(4096, 1, 1024, 1);   // widest line, four samples per cell
    send_frames(120);
    drain();                      // sender holds until all cells are back
    send_idle = 33; recv_stall = 33;
    set_grid(7, 9, 7, 3);
    send_frames(200);
    send_idle = 0; recv_stall = 0;
    set_grid(1, 4096, 1, 1024);
    send_frames(100);
    // shrink mid-frame: position falls outside, then wraps
    set_grid(9, 9, 3, 3);
    send_frames(40);
    drain();
    write_reg(RegWidth, 3);
    write_reg(RegHeight, 2);
    send_idle = 33; recv_stall = 33;
    for (int i = 0; i < 80; i++) send_pixel(rnd_pixel(0));
    send_frames(40);

    drain();
    if (fails == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
